/* rtl/cse_pkg.sv */
// shared types, character codes and escape lookup for the c string byte escaper
`timescale 1ns / 1ps

package cse_pkg;

  // most characters one byte can expand into
  localparam int MaxRun  = 4;
  localparam int RunIdxW = $clog2(MaxRun);
  localparam int CharW   = 7;

  // ascii codes used by the escaper
  localparam logic [CharW-1:0] CharBackslash = 7'h5C;
  localparam logic [CharW-1:0] CharZero      = 7'h30;
  localparam logic [7:0]       PrintLow      = 8'h20;
  localparam logic [7:0]       PrintHigh     = 8'h7E;

  // expansion of one byte, ready for the serializer
  typedef struct packed {
    logic [MaxRun-1:0][CharW-1:0] chars;
    logic [RunIdxW-1:0]           last_idx;
    logic                         fin;
  } cse_run_t;

  // result of the short escape lookup
  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] code;
  } cse_short_t;

  // two-character escapes: control codes, the four marks and nul
  function automatic cse_short_t short_escape(input logic [7:0] b);
    cse_short_t r;
    r.hit = 1'b1;
    unique case (b)
      8'h07:   r.code = 7'h61; // a
      8'h08:   r.code = 7'h62; // b
      8'h0C:   r.code = 7'h66; // f
      8'h0A:   r.code = 7'h6E; // n
      8'h0D:   r.code = 7'h72; // r
      8'h09:   r.code = 7'h74; // t
      8'h0B:   r.code = 7'h76; // v
      8'h5C:   r.code = 7'h5C; // backslash
      8'h27:   r.code = 7'h27; // single quote
      8'h22:   r.code = 7'h22; // double quote
      8'h3F:   r.code = 7'h3F; // question mark
      8'h00:   r.code = 7'h30; // nul as digit zero
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  // octal digit as an ascii character
  function automatic logic [CharW-1:0] oct_char(input logic [2:0] d);
    return CharZero | {4'b0000, d};
  endfunction

endpackage

/* rtl/cse_encode.sv */
// expands one registered byte into its escaped characters and run length
`timescale 1ns / 1ps

module cse_encode import cse_pkg::*; (
  input  logic [7:0] byte_val,
  input  logic       fin,
  output cse_run_t   run
);

  cse_short_t sh;
  logic       printable;

  // classify the byte
  always_comb begin
    sh        = short_escape(byte_val);
    printable = (byte_val >= PrintLow) && (byte_val <= PrintHigh);
  end

  // build the character run
  always_comb begin
    run.chars = '0;
    run.fin   = fin;
    if (printable && !sh.hit) begin
      run.chars[0] = byte_val[CharW-1:0];
      run.last_idx = RunIdxW'(0);
    end else if (sh.hit) begin
      run.chars[0] = CharBackslash;
      run.chars[1] = sh.code;
      run.last_idx = RunIdxW'(1);
    end else begin
      run.chars[0] = CharBackslash;
      priority if (byte_val[7:6] != 2'b00) begin
        run.chars[1] = oct_char({1'b0, byte_val[7:6]});
        run.chars[2] = oct_char(byte_val[5:3]);
        run.chars[3] = oct_char(byte_val[2:0]);
        run.last_idx = RunIdxW'(3);
      end else if (byte_val[5:3] != 3'b000) begin
        run.chars[1] = oct_char(byte_val[5:3]);
        run.chars[2] = oct_char(byte_val[2:0]);
        run.last_idx = RunIdxW'(2);
      end else begin
        run.chars[1] = oct_char(byte_val[2:0]);
        run.last_idx = RunIdxW'(1);
      end
    end
  end

endmodule

/* rtl/cse_serial.sv */
// result register that sends one run of characters out, one per cycle while out_stall is low
`timescale 1ns / 1ps

module cse_serial import cse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cse_run_t         run_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] char_out,
  output logic             run_last,
  output logic             string_end
);

  cse_run_t           run;
  logic               busy;
  logic               busy_next;
  logic [RunIdxW-1:0] idx;
  logic [RunIdxW-1:0] idx_next;
  logic               at_last;
  logic               done;

  // run position and handoff
  always_comb begin
    at_last = (idx == run.last_idx);
    done    = busy && at_last && !out_stall;
    free    = !busy || done;
  end

  // next control state
  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    if (load) begin
      busy_next = 1'b1;
      idx_next  = '0;
    end else if (done) begin
      busy_next = 1'b0;
    end else if (busy && !out_stall) begin
      idx_next = idx + RunIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

  // output item
  assign out_valid  = busy;
  assign char_out   = run.chars[idx];
  assign run_last   = at_last;
  assign string_end = at_last && run.fin;

endmodule

/* rtl/c_string_byte_escaper_unit.sv */
// top level of the c string byte escaper: input register, encoder, serializer
`timescale 1ns / 1ps

// Escapes a string one raw byte at a time into C source text.
// Input channel: in_valid / in_stall with byte_in and final_byte; an item
// is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with char_out, run_last and
// string_end; one ASCII character per item, run_last on the last
// character of a byte, string_end on that character when final_byte was set.
// Each byte yields one to four characters: plain printable bytes one,
// short escapes two, octal escapes two to four.
// The first character of a byte passes the input register, then the result
// register, before it leaves on the output.
// Throughput: one output character per cycle while out_stall is low; a new
// byte is taken every cycle while bytes expand to a single character and
// the output is not stalled.
// A stalled output holds its character; the input register then fills and
// in_stall rises until the current run drains.
// Reset (rst, synchronous) empties both registers; no clearing pass.
module c_string_byte_escaper_unit import cse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       byte_in,
  input  logic             final_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] char_out,
  output logic             run_last,
  output logic             string_end
);

  logic       held;
  logic       held_next;
  logic [7:0] held_byte;
  logic       held_fin;
  logic       take;
  logic       advance;
  logic       ser_free;
  cse_run_t   run;

  // input register handshake
  always_comb begin
    advance   = held && ser_free;
    in_stall  = held && !ser_free;
    take      = in_valid && !in_stall;
    held_next = take ? 1'b1 : (advance ? 1'b0 : held);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= byte_in;
      held_fin  <= final_byte;
    end
  end

  // escape expansion
  cse_encode u_encode (
    .byte_val (held_byte),
    .fin      (held_fin),
    .run      (run)
  );

  // character output
  cse_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .run_in     (run),
    .free       (ser_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

/* tb/c_string_byte_escaper_unit_test.sv */
// self-checking testbench for the c string byte escaper
`timescale 1ns / 1ps

module c_string_byte_escaper_unit_test;
  import cse_pkg::*;

  // run length guard and end-of-run settings
  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 12;
  localparam int CalmTail     = 30;
  localparam int RandomBytes  = 76;

  // one raw byte waiting to be sent
  typedef struct {
    logic [7:0] value;
    logic       fin;
  } raw_byte_t;

  // one escaped character the block should produce
  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    logic             fin;
  } esc_char_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       byte_in = 8'h00;
  logic             final_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] char_out;
  logic             run_last;
  logic             string_end;

  raw_byte_t pending_bytes[$];
  esc_char_t escaped_chars[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_gap = 0;
  int        stall_left = 0;

  c_string_byte_escaper_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .run_last   (run_last),
    .string_end (string_end)
  );

  // letter after the backslash for two-character escapes, zero if none
  function automatic logic [7:0] escape_letter(input logic [7:0] b);
    case (b)
      8'h07:   return "a";
      8'h08:   return "b";
      8'h0C:   return "f";
      8'h0A:   return "n";
      8'h0D:   return "r";
      8'h09:   return "t";
      8'h0B:   return "v";
      8'h5C:   return "\\";
      8'h27:   return "'";
      8'h22:   return "\"";
      8'h3F:   return "?";
      8'h00:   return "0";
      default: return 8'h00;
    endcase
  endfunction

  // expand one accepted byte into the characters it should produce
  function automatic void predict_escape(input logic [7:0] b, input logic fin);
    logic [7:0] text[$];
    logic [7:0] letter;
    esc_char_t  c;
    letter = escape_letter(b);
    if (b >= PrintLow && b <= PrintHigh && letter == 8'h00) begin
      text.push_back(b);
    end else if (letter != 8'h00) begin
      text.push_back({1'b0, CharBackslash});
      text.push_back(letter);
    end else begin
      // octal digits without leading zeros
      text.push_back({1'b0, CharBackslash});
      if (b >= 8'd64) text.push_back({1'b0, CharZero} + {6'd0, b[7:6]});
      if (b >= 8'd8) text.push_back({1'b0, CharZero} + {5'd0, b[5:3]});
      text.push_back({1'b0, CharZero} + {5'd0, b[2:0]});
    end
    foreach (text[k]) begin
      c.ch   = text[k][CharW-1:0];
      c.last = (k == text.size() - 1);
      c.fin  = c.last & fin;
      escaped_chars.push_back(c);
    end
  endfunction

  // compare one accepted character with the oldest expected one
  task automatic check_char();
    esc_char_t want;
    if (escaped_chars.size() == 0) begin
      $error("unexpected character: char_out %h run_last %b string_end %b",
             char_out, run_last, string_end);
      mismatches++;
    end else begin
      want = escaped_chars.pop_front();
      if (char_out !== want.ch) begin
        $error("char_out: expected %h, actual %h", want.ch, char_out);
        mismatches++;
      end
      if (run_last !== want.last) begin
        $error("run_last: expected %b, actual %b", want.last, run_last);
        mismatches++;
      end
      if (string_end !== want.fin) begin
        $error("string_end: expected %b, actual %b", want.fin, string_end);
        mismatches++;
      end
    end
  endtask

  function automatic void queue_byte(input logic [7:0] value, input logic fin);
    raw_byte_t r;
    r.value = value;
    r.fin   = fin;
    pending_bytes.push_back(r);
  endfunction

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // input driver: sends the next byte whenever the slot is free, with random idle gaps
  always @(posedge clk) begin : drive_bytes
    raw_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_escape(byte_in, final_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          byte_in    <= nxt.value;
          final_byte <= nxt.fin;
          in_valid   <= 1'b1;
          if (pending_bytes.size() > CalmTail && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_char();
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (pending_bytes.size() > CalmTail && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("c_string_byte_escaper_unit verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // directed bytes: escapes, octal widths, printable edges, high bytes
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h06, 1'b0);
    queue_byte(8'h07, 1'b0);
    queue_byte(8'h08, 1'b1);
    queue_byte(8'h09, 1'b0);
    queue_byte(8'h0A, 1'b0);
    queue_byte(8'h0B, 1'b1);
    queue_byte(8'h0C, 1'b0);
    queue_byte(8'h0D, 1'b0);
    queue_byte(8'h0E, 1'b1);
    queue_byte(8'h1F, 1'b0);
    queue_byte(8'h20, 1'b1);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h27, 1'b0);
    queue_byte(8'h3F, 1'b1);
    queue_byte(8'h5C, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h7E, 1'b1);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // random bytes split among control, printable and high ranges
    for (int i = 0; i < RandomBytes; i++) begin
      case ($urandom_range(0, 2))
        0:       queue_byte(8'($urandom_range(0, 31)), $urandom_range(0, 7) == 0);
        1:       queue_byte(8'($urandom_range(32, 127)), $urandom_range(0, 7) == 0);
        default: queue_byte(8'($urandom_range(128, 255)), $urandom_range(0, 7) == 0);
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (escaped_chars.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("c_string_byte_escaper_unit verification clean");
    end else begin
      $display("c_string_byte_escaper_unit verification failed");
    end
    $finish;
  end

endmodule
